@@ rtl/dtbe_pkg.sv @@
package dtbe_pkg;

	localparam int NUM_TRACKS = 16;
	localparam int TRACK_W = 4;
	localparam int DELTA_W = 16;
	localparam int TICK_W = 12;
	localparam int BYTE_W = 8;
	localparam int ALU_W = TICK_W + 1;
	localparam int REG_IDX_W = 2;

	localparam logic [TICK_W-1:0] OVF_TICKS = 12'd240;
	localparam logic [TICK_W-1:0] OVF_TICKS_M1 = 12'd239;
	localparam logic [TICK_W-1:0] BAR_MIN = 12'd240;
	localparam logic [TICK_W-1:0] BAR_MAX = 12'd3840;
	localparam logic [TICK_W-1:0] DELTA_MAX = 12'd4095;

	localparam logic [TICK_W-1:0] RST_TICKS_PER_BAR = 12'd480;
	localparam logic [BYTE_W-1:0] RST_OVERFLOW_CODE = 8'd248;
	localparam logic [BYTE_W-1:0] RST_MEASURE_END_CODE = 8'd249;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TICKS_PER_BAR = 2'd0,
		REG_OVERFLOW_CODE = 2'd1,
		REG_MEASURE_END_CODE = 2'd2
	} reg_idx_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_LOAD  = 6'b000010,
		S_CHECK = 6'b000100,
		S_FIRST = 6'b001000,
		S_SPAN  = 6'b010000,
		S_MEND  = 6'b100000
	} state_t;

	typedef struct packed {
		logic [ALU_W-1:0] diff;
		logic             borrow;
	} alu_res_t;

	typedef struct packed {
		logic              we;
		logic [TRACK_W-1:0] idx;
		logic [TICK_W-1:0]  data;
	} pos_wr_t;

endpackage

@@ rtl/delta_time_bar_encoder_core.sv @@
// Delta-time bar encoder. An item (track, delta_ticks) is turned into a run of
// track bytes, one byte per cycle on the output channel unless out_stall holds
// it, with last set on the final byte and clamped set on every byte when the
// delta was above 4095. Each track keeps its position in the current bar,
// cleared to zero at reset. The block takes one item at a time: after
// acceptance it passes through the setup states S_LOAD and S_CHECK (and S_FIRST
// when the delta crosses a bar end) and then emits the bytes through a single
// shared 13-bit subtractor. in_stall stays high until the last byte has been
// loaded into the output register. Configuration should be written only while
// the block is idle.
module delta_time_bar_encoder_core import dtbe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [TICK_W-1:0]    wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [TRACK_W-1:0]   track,
	input  logic [DELTA_W-1:0]   delta_ticks,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BYTE_W-1:0]    out_byte,
	output logic                 last,
	output logic                 clamped
);

	state_t              state_q;
	logic [TICK_W-1:0]   ticks_per_bar_q;
	logic [BYTE_W-1:0]   overflow_code_q;
	logic [BYTE_W-1:0]   measure_end_code_q;

	logic [TRACK_W-1:0]  track_q;
	logic [TICK_W-1:0]   d_q;
	logic                clamp_q;
	logic [TICK_W-1:0]   bar_q;
	logic [TICK_W-1:0]   pos_q;
	logic [TICK_W-1:0]   rem_q;
	logic [TICK_W-1:0]   over_q;
	logic                final_q;

	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                last_q;
	logic                clamped_q;

	logic                in_acc;
	logic                can_emit;
	logic [TICK_W-1:0]   bar_eff;
	logic [TICK_W-1:0]   pos_rd;
	logic [ALU_W-1:0]    total;
	logic [ALU_W-1:0]    op_a;
	logic [ALU_W-1:0]    op_b;
	alu_res_t            alu;
	pos_wr_t             pos_wr;

	assign in_stall = state_q != S_IDLE;
	assign in_acc = in_valid && !in_stall;
	assign can_emit = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign last = last_q;
	assign clamped = clamped_q;

	assign bar_eff = (ticks_per_bar_q < BAR_MIN) ? BAR_MIN :
		(ticks_per_bar_q > BAR_MAX) ? BAR_MAX : ticks_per_bar_q;
	assign total = {1'b0, pos_q} + {1'b0, d_q};

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_LOAD: begin
				op_a = {1'b0, pos_rd};
				op_b = {1'b0, bar_q};
			end
			S_CHECK: begin
				op_a = total;
				op_b = {1'b0, bar_q};
			end
			S_FIRST: begin
				op_a = {1'b0, bar_q};
				op_b = {1'b0, pos_q};
			end
			S_SPAN: begin
				op_a = {1'b0, rem_q};
				op_b = {1'b0, OVF_TICKS};
			end
			S_MEND: begin
				op_a = {1'b0, over_q};
				op_b = {1'b0, bar_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	dtbe_alu u_alu (
		.a   (op_a),
		.b   (op_b),
		.res (alu)
	);

	always_comb begin
		pos_wr.we = 1'b0;
		pos_wr.idx = track_q;
		pos_wr.data = total[TICK_W-1:0];
		if (state_q == S_CHECK && alu.borrow) begin
			pos_wr.we = 1'b1;
		end else if (state_q == S_MEND && can_emit && alu.borrow) begin
			pos_wr.we = 1'b1;
			pos_wr.data = over_q;
		end
	end

	dtbe_pos_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (track_q),
		.rd_data (pos_rd),
		.wr      (pos_wr)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			ticks_per_bar_q <= RST_TICKS_PER_BAR;
			overflow_code_q <= RST_OVERFLOW_CODE;
			measure_end_code_q <= RST_MEASURE_END_CODE;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_TICKS_PER_BAR: ticks_per_bar_q <= wr_data;
					REG_OVERFLOW_CODE: overflow_code_q <= wr_data[BYTE_W-1:0];
					REG_MEASURE_END_CODE: measure_end_code_q <= wr_data[BYTE_W-1:0];
					default: ;
				endcase
			end
			if (can_emit && (state_q == S_SPAN || state_q == S_MEND)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) state_q <= S_LOAD;
				end
				S_LOAD: state_q <= S_CHECK;
				S_CHECK: state_q <= alu.borrow ? S_SPAN : S_FIRST;
				S_FIRST: state_q <= S_SPAN;
				S_SPAN: begin
					if (can_emit && alu.borrow) state_q <= final_q ? S_IDLE : S_MEND;
				end
				S_MEND: begin
					if (can_emit) state_q <= S_SPAN;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					track_q <= track;
					clamp_q <= delta_ticks > DELTA_W'(DELTA_MAX);
					d_q <= (delta_ticks > DELTA_W'(DELTA_MAX)) ? DELTA_MAX :
						delta_ticks[TICK_W-1:0];
					bar_q <= bar_eff;
				end
			end
			S_LOAD: begin
				pos_q <= alu.borrow ? pos_rd : bar_q - 12'd1;
			end
			S_CHECK: begin
				if (alu.borrow) begin
					rem_q <= d_q;
					final_q <= 1'b1;
				end else begin
					over_q <= alu.diff[TICK_W-1:0];
					final_q <= 1'b0;
				end
			end
			S_FIRST: begin
				rem_q <= alu.diff[TICK_W-1:0];
			end
			S_SPAN: begin
				if (can_emit) begin
					clamped_q <= clamp_q;
					if (alu.borrow) begin
						out_byte_q <= rem_q[BYTE_W-1:0];
						last_q <= final_q;
					end else begin
						out_byte_q <= overflow_code_q;
						last_q <= 1'b0;
						rem_q <= alu.diff[TICK_W-1:0];
					end
				end
			end
			S_MEND: begin
				if (can_emit) begin
					clamped_q <= clamp_q;
					out_byte_q <= measure_end_code_q;
					last_q <= 1'b0;
					if (alu.borrow) begin
						rem_q <= over_q;
						final_q <= 1'b1;
					end else begin
						rem_q <= bar_q;
						over_q <= alu.diff[TICK_W-1:0];
						final_q <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	a_bar_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (bar_q >= BAR_MIN && bar_q <= BAR_MAX))
		else $error("bar length out of range during a run");

	a_pos_in_bar: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK || state_q == S_FIRST) |-> (pos_q < bar_q))
		else $error("bar position not below bar length");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPAN && can_emit && alu.borrow && final_q) |=>
		(out_valid && last && state_q == S_IDLE))
		else $error("final byte did not end the run");

	a_span_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPAN && alu.borrow) |-> (rem_q <= OVF_TICKS_M1))
		else $error("remainder byte out of range");

endmodule

@@ rtl/dtbe_alu.sv @@
module dtbe_alu import dtbe_pkg::*; (
	input  logic [ALU_W-1:0] a,
	input  logic [ALU_W-1:0] b,
	output alu_res_t         res
);

	logic [ALU_W:0] full;

	assign full = {1'b0, a} - {1'b0, b};
	assign res.diff = full[ALU_W-1:0];
	assign res.borrow = full[ALU_W];

endmodule

@@ rtl/dtbe_pos_store.sv @@
module dtbe_pos_store import dtbe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [TRACK_W-1:0] rd_idx,
	output logic [TICK_W-1:0]  rd_data,
	input  pos_wr_t            wr
);

	logic [TICK_W-1:0] pos_q [NUM_TRACKS];
	logic              rd_ok;
	logic              wr_ok;

	assign rd_ok = int'(rd_idx) < NUM_TRACKS;
	assign wr_ok = int'(wr.idx) < NUM_TRACKS;
	assign rd_data = rd_ok ? pos_q[rd_idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TRACKS; i++) begin
				pos_q[i] <= '0;
			end
		end else if (wr.we && wr_ok) begin
			pos_q[wr.idx] <= wr.data;
		end
	end

endmodule
